// ===== rtl/core/skfk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skfk_pkg
// Shared types, constants and a saturation helper for the skeleton
// forward kinematics block.
// ----------------------------------------------------------------------------
package skfk_pkg;

  localparam int SKFK_MAX_BONES = 64;
  localparam int LANES = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUAT,
    ST_LOC,
    ST_GLOB,
    ST_OUT
  } state_t;

  localparam logic signed [51:0] ONE_Q = 52'sd65536;

  // Operand selects for the quaternion products: x=0, y=1, z=2, w=3.
  // Order of products: xx yy zz xy xz yz wx wy wz.
  localparam logic [1:0] QUAT_A [12] = '{2'd0, 2'd1, 2'd2, 2'd0,
                                         2'd0, 2'd1, 2'd3, 2'd3,
                                         2'd3, 2'd0, 2'd0, 2'd0};
  localparam logic [1:0] QUAT_B [12] = '{2'd0, 2'd1, 2'd2, 2'd1,
                                         2'd2, 2'd2, 2'd0, 2'd1,
                                         2'd2, 2'd0, 2'd0, 2'd0};

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -52'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/skfk_mul4.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skfk_mul4
// Four multiplier lanes on Q16.16 operands with a registered 64-bit product and
// round-half-up to Q32.16 on the output.
// ----------------------------------------------------------------------------
module skfk_mul4 import skfk_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] op_a [LANES],
  input  logic signed [31:0] op_b [LANES],
  output logic signed [47:0] res  [LANES]
);

  logic signed [63:0] prod_r [LANES];
  logic signed [63:0] bias   [LANES];

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      prod_r[l] <= op_a[l] * op_b[l];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      bias[l] = prod_r[l] + 64'sd32768;
      res[l]  = bias[l][63:16];
    end
  end

endmodule

// ===== rtl/core/skfk_mat_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skfk_mat_mem
// Global matrix store, one matrix row of four words per entry, with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module skfk_mat_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [127:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [127:0]  rdata
);

  logic [127:0] mem [DEPTH];
  logic [127:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/skeleton_forward_kinematics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeleton_forward_kinematics
// Builds each bone's local TRS matrix, multiplies it by the parent's stored
// global matrix if there is a parent; emits the result as four row items.
// ----------------------------------------------------------------------------
// Each accepted bone passes through the quaternion and local-matrix steps and,
// with a parent, the 16-step walk over the parent's rows; its four rows then
// leave one per cycle while the output is not stalled. A new bone is accepted
// only once the last row of the previous bone has been issued; the pace is set
// by the four multiplier lanes and that walk.
// Reset clears the bone counter and the control state; the matrix store is
// not cleared.
module skeleton_forward_kinematics import skfk_pkg::*; #(
  parameter int MAX_BONES = SKFK_MAX_BONES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // trans_x, trans_y, trans_z, rot_x, rot_y, rot_z, rot_w,
  // scale_x, scale_y, scale_z, parent_index, zero pad.
  input  logic [327:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index, elem_0, elem_1, elem_2, elem_3, zero pad.
  output logic [135:0] out_tdata,
  output logic         out_tlast,
  // order_error.
  output logic         out_tuser
);

  localparam int BW    = (MAX_BONES > 2) ? $clog2(MAX_BONES) : 1;
  localparam int CW    = (BW > 6) ? BW : 6;
  localparam int AW    = BW + 2;
  localparam int DEPTH = MAX_BONES * 4;

  state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cm1, cm2;
  logic [BW-1:0] cur_r, par_r;
  logic has_par_r, err_r, last_r;
  logic [1:0] row_r;

  logic signed [31:0] trans_r [3];
  logic signed [31:0] quat_r  [4];
  logic signed [31:0] scl_r   [3];
  logic signed [47:0] q_r     [12];
  logic signed [31:0] loc_r   [3][3];
  logic signed [49:0] acc_r   [4][4];

  logic signed [31:0] rot      [3][3];
  logic signed [31:0] loc_full [4][4];
  logic signed [31:0] glob_row [4];

  logic signed [31:0] op_a [LANES];
  logic signed [31:0] op_b [LANES];
  logic signed [47:0] res  [LANES];

  logic         mem_we, mem_re;
  logic [127:0] mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic         out_valid_r, out_last_r, out_err_r;
  logic [135:0] out_data_r;
  logic         accept, adv;

  logic [6:0]    in_par;
  logic [CW-1:0] par_ext;
  logic          hp_in;

  assign accept = in_tvalid && in_tready;
  assign adv    = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign cm1    = cnt_r - 5'd1;
  assign cm2    = cnt_r - 5'd2;

  assign in_par  = in_tdata[326:320];
  assign par_ext = CW'(in_par[5:0]);
  assign hp_in   = !in_par[6] && (par_ext < CW'(cur_r));

  skfk_mul4 u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .res  (res)
  );

  skfk_mat_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({glob_row[3], glob_row[2], glob_row[1], glob_row[0]}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    rot[0][0] = sat32(ONE_Q - ((52'(q_r[1]) + 52'(q_r[2])) <<< 1));
    rot[0][1] = sat32((52'(q_r[3]) + 52'(q_r[8])) <<< 1);
    rot[0][2] = sat32((52'(q_r[4]) - 52'(q_r[7])) <<< 1);
    rot[1][0] = sat32((52'(q_r[3]) - 52'(q_r[8])) <<< 1);
    rot[1][1] = sat32(ONE_Q - ((52'(q_r[0]) + 52'(q_r[2])) <<< 1));
    rot[1][2] = sat32((52'(q_r[5]) + 52'(q_r[6])) <<< 1);
    rot[2][0] = sat32((52'(q_r[4]) + 52'(q_r[7])) <<< 1);
    rot[2][1] = sat32((52'(q_r[5]) - 52'(q_r[6])) <<< 1);
    rot[2][2] = sat32(ONE_Q - ((52'(q_r[0]) + 52'(q_r[1])) <<< 1));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        loc_full[i][j] = loc_r[i][j];
      end
      loc_full[i][3] = '0;
      loc_full[3][i] = trans_r[i];
    end
    loc_full[3][3] = 32'sd65536;
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (has_par_r) begin
        glob_row[j] = sat32(52'(acc_r[row_r][j]));
      end else begin
        glob_row[j] = loc_full[row_r][j];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_QUAT;
      ST_QUAT: if (cnt_r == 5'd3) state_nxt = ST_LOC;
      ST_LOC: begin
        if (cnt_r == 5'd3) state_nxt = has_par_r ? ST_GLOB : ST_OUT;
      end
      ST_GLOB: if (cnt_r == 5'd17) state_nxt = ST_OUT;
      ST_OUT: if (adv && row_r == 2'd3) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mem_we    = adv;
    mem_waddr = {cur_r, row_r};
    mem_re    = (state_r == ST_GLOB) && (cnt_r[1:0] == 2'd0) && !cnt_r[4];
    mem_raddr = {par_r, cnt_r[3:2]};
    for (int l = 0; l < LANES; l++) begin
      op_a[l] = '0;
      op_b[l] = '0;
    end
    unique case (state_r)
      ST_QUAT: begin
        if (cnt_r < 5'd3) begin
          for (int l = 0; l < LANES; l++) begin
            op_a[l] = quat_r[QUAT_A[{cnt_r[1:0], 2'(l)}]];
            op_b[l] = quat_r[QUAT_B[{cnt_r[1:0], 2'(l)}]];
          end
        end
      end
      ST_LOC: begin
        if (cnt_r < 5'd3) begin
          for (int l = 0; l < 3; l++) begin
            op_a[l] = scl_r[cnt_r[1:0]];
            op_b[l] = rot[cnt_r[1:0]][l];
          end
        end
      end
      ST_GLOB: begin
        for (int l = 0; l < LANES; l++) begin
          op_a[l] = loc_full[cm1[1:0]][cm1[3:2]];
          op_b[l] = mem_rdata[32*l +: 32];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cur_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 5'd0 : cnt_r + 5'd1;
      if (state_nxt == ST_OUT && state_r != ST_OUT) begin
        row_r <= '0;
      end else if (adv) begin
        row_r <= row_r + 2'd1;
      end
      if (adv && row_r == 2'd3) begin
        if (last_r || cur_r == BW'(MAX_BONES - 1)) begin
          cur_r <= '0;
        end else begin
          cur_r <= cur_r + 1'b1;
        end
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        trans_r[i] <= in_tdata[32*i +: 32];
        scl_r[i]   <= in_tdata[32*(i+7) +: 32];
      end
      for (int i = 0; i < 4; i++) begin
        quat_r[i] <= in_tdata[32*(i+3) +: 32];
      end
      par_r     <= par_ext[BW-1:0];
      has_par_r <= hp_in;
      err_r     <= !in_par[6] && !hp_in;
      last_r    <= in_tlast;
    end
    if (state_r == ST_QUAT && cnt_r != 5'd0) begin
      for (int l = 0; l < LANES; l++) begin
        q_r[{cm1[1:0], 2'(l)}] <= res[l];
      end
    end
    if (state_r == ST_LOC && cnt_r != 5'd0) begin
      for (int l = 0; l < 3; l++) begin
        loc_r[cm1[1:0]][l] <= sat32(52'(res[l]));
      end
    end
    if (state_r == ST_GLOB && cnt_r >= 5'd2) begin
      for (int l = 0; l < LANES; l++) begin
        acc_r[cm2[1:0]][l] <= ((cm2[3:2] == 2'd0) ? 50'sd0 : acc_r[cm2[1:0]][l])
                              + 50'(res[l]);
      end
    end
    if (adv) begin
      out_data_r <= {6'd0, glob_row[3], glob_row[2], glob_row[1], glob_row[0], row_r};
      out_last_r <= (row_r == 2'd3);
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

`ifndef ASSERT_OFF
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[1:0] == 2'd3)))
    else $error("last row flag does not match row index");

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= BW'(MAX_BONES - 1))
    else $error("bone counter out of range");

  a_glob_parent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GLOB) |-> has_par_r)
    else $error("parent product without a parent");
`endif

endmodule
